### src/u8u16_pkg.sv
// Shared types, constants and helper functions for the UTF-8 to UTF-16 decoder.
// No dependencies; used by every module of the block.
package u8u16_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_CUTOFF  = 2'd2
  } status_t;

  localparam logic [7:0]  LEAD_MIN       = 8'hC2;
  localparam logic [7:0]  LEAD_MAX       = 8'hF4;
  localparam logic [7:0]  LEAD_E0        = 8'hE0;
  localparam logic [7:0]  LEAD_ED        = 8'hED;
  localparam logic [7:0]  LEAD_F0        = 8'hF0;
  localparam logic [7:0]  LEAD_F4        = 8'hF4;
  localparam logic [7:0]  CONT_MIN       = 8'h80;
  localparam logic [7:0]  CONT_MAX       = 8'hBF;
  localparam logic [7:0]  E0_SECOND_MIN  = 8'hA0;
  localparam logic [7:0]  ED_SECOND_MAX  = 8'h9F;
  localparam logic [7:0]  F0_SECOND_MIN  = 8'h90;
  localparam logic [7:0]  F4_SECOND_MAX  = 8'h8F;
  localparam logic [20:0] BMP_MAX        = 21'h00FFFF;
  localparam logic [20:0] SUPP_BASE      = 21'h010000;
  localparam logic [15:0] HI_SURR_BASE   = 16'hD800;
  localparam logic [5:0]  LO_SURR_PREFIX = 6'b110111;

  // Word(s) produced by one decode step.
  typedef struct packed {
    logic [1:0]  n;
    logic [15:0] unit0;
    status_t     status0;
    logic        last0;
    logic [15:0] unit1;
  } res_t;

  typedef struct packed {
    logic free;
    logic pend;
  } out_ctl_t;

  function automatic logic [2:0] trail_count(input logic [7:0] b);
    logic [2:0] t;
    if (b < 8'hC0)      t = 3'd0;
    else if (b < 8'hE0) t = 3'd1;
    else if (b < 8'hF0) t = 3'd2;
    else if (b < 8'hF8) t = 3'd3;
    else if (b < 8'hFC) t = 3'd4;
    else                t = 3'd5;
    return t;
  endfunction

  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
    logic ok;
    if (b > CONT_MAX) ok = 1'b0;
    else if (lead == LEAD_E0) ok = (b >= E0_SECOND_MIN);
    else if (lead == LEAD_ED) ok = (b <= ED_SECOND_MAX);
    else if (lead == LEAD_F0) ok = (b >= F0_SECOND_MIN);
    else if (lead == LEAD_F4) ok = (b <= F4_SECOND_MAX);
    else ok = (b >= CONT_MIN);
    return ok;
  endfunction

endpackage

### src/utf8_to_utf16_decoder.sv
// Top level of the UTF-8 to UTF-16 decoder: input register, decode step, output stage.
// Depends on u8u16_pkg, u8u16_step and u8u16_out.
//
// Usage:
//   Input channel: in_valid / in_stall with in_byte and end_of_input, one UTF-8
//   byte per word; end_of_input marks the last byte of a buffer.
//   Output channel: out_valid / out_stall with code_unit, status and
//   last_of_run. A code point above 0xFFFF gives two words (high then low
//   surrogate); errors give one word with status 1 (illegal) or 2 (cut off)
//   and code_unit 0. After an illegal sequence, bytes are dropped up to the
//   end of the buffer.
//   Path: a byte is accepted into the input register, decoded, and its word is
//   registered in the output register. Throughput: one byte per cycle while the
//   output is not stalled; a byte completing a surrogate pair holds the decode
//   step while the low half moves from the holding slot to the output register.
//   Reset (rst, synchronous) empties the input and output registers and
//   returns the decoder to expecting a lead byte.
//   When out_stall is high the output word holds; the input register and the
//   decoder keep moving for bytes that produce no word, otherwise in_stall
//   rises in the same cycle.
module utf8_to_utf16_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_unit,
  output logic [1:0]  status,
  output logic        last_of_run
);
  import u8u16_pkg::*;

  logic       r_valid;
  logic [7:0] r_byte;
  logic       r_eoi;
  logic       fire;
  res_t       res;
  out_ctl_t   ctl;

  assign fire     = r_valid && !ctl.pend && (res.n == 2'd0 || ctl.free);
  assign in_stall = r_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      r_valid <= 1'b1;
    end else if (fire) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      r_byte <= in_byte;
      r_eoi  <= end_of_input;
    end
  end

  u8u16_step u_step (
    .clk     (clk),
    .rst     (rst),
    .byte_in (r_byte),
    .eoi     (r_eoi),
    .fire    (fire),
    .res     (res)
  );

  u8u16_out u_out (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .res         (res),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .code_unit   (code_unit),
    .status      (status),
    .last_of_run (last_of_run),
    .ctl         (ctl)
  );

endmodule

### src/u8u16_step.sv
// Sequence state and per-byte decode: validates one byte, builds the code point
// and forms up to two result words. Depends on u8u16_pkg.
module u8u16_step (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         byte_in,
  input  logic               eoi,
  input  logic               fire,
  output u8u16_pkg::res_t    res
);
  import u8u16_pkg::*;

  logic [20:0] partial_value, partial_value_next;
  logic [2:0]  bytes_remaining, bytes_remaining_next;
  logic [7:0]  lead_byte, lead_byte_next;
  logic [2:0]  seq_position, seq_position_next;
  logic        seq_bad, seq_bad_next;
  logic        halted, halted_next;

  logic [2:0]  t;
  logic        bad_now;
  logic [20:0] pv_shift;
  logic [2:0]  rem_dec;
  logic [20:0] v;

  assign t        = trail_count(byte_in);
  assign pv_shift = {partial_value[14:0], byte_in[5:0]};
  assign rem_dec  = bytes_remaining - 3'd1;
  assign v        = pv_shift - SUPP_BASE;
  assign bad_now  = (seq_position == 3'd1) ? !second_ok(lead_byte, byte_in)
                                           : (byte_in < CONT_MIN || byte_in > CONT_MAX);

  always_comb begin
    partial_value_next   = partial_value;
    bytes_remaining_next = bytes_remaining;
    lead_byte_next       = lead_byte;
    seq_position_next    = seq_position;
    seq_bad_next         = seq_bad;
    halted_next          = halted;
    res.n       = 2'd0;
    res.unit0   = '0;
    res.status0 = ST_OK;
    res.last0   = 1'b1;
    res.unit1   = {LO_SURR_PREFIX, v[9:0]};

    if (halted) begin
      if (eoi) halted_next = 1'b0;
    end else if (bytes_remaining == 3'd0) begin
      if (t == 3'd0) begin
        res.n = 2'd1;
        if (byte_in >= CONT_MIN) begin
          res.status0 = ST_ILLEGAL;
          halted_next = !eoi;
        end else begin
          res.unit0 = {8'h00, byte_in};
        end
      end else if (eoi) begin
        res.n       = 2'd1;
        res.status0 = ST_CUTOFF;
      end else begin
        lead_byte_next       = byte_in;
        bytes_remaining_next = t;
        seq_position_next    = 3'd1;
        seq_bad_next         = (byte_in < LEAD_MIN || byte_in > LEAD_MAX || t > 3'd3);
        case (t)
          3'd1:    partial_value_next = {16'd0, byte_in[4:0]};
          3'd2:    partial_value_next = {17'd0, byte_in[3:0]};
          default: partial_value_next = {18'd0, byte_in[2:0]};
        endcase
      end
    end else begin
      partial_value_next   = pv_shift;
      seq_position_next    = seq_position + 3'd1;
      bytes_remaining_next = rem_dec;
      seq_bad_next         = seq_bad | bad_now;
      if (rem_dec != 3'd0) begin
        if (eoi) begin
          res.n       = 2'd1;
          res.status0 = ST_CUTOFF;
        end
      end else begin
        res.n = 2'd1;
        if (seq_bad || bad_now) begin
          res.status0 = ST_ILLEGAL;
          halted_next = !eoi;
        end else if (pv_shift <= BMP_MAX) begin
          res.unit0 = pv_shift[15:0];
        end else begin
          res.n     = 2'd2;
          res.unit0 = 16'(v[20:10]) + HI_SURR_BASE;
          res.last0 = 1'b0;
        end
      end
    end

    // Any reported word or end of buffer returns the sequence state to idle.
    if (!halted && (res.n != 2'd0 || eoi)) begin
      partial_value_next   = '0;
      bytes_remaining_next = '0;
      lead_byte_next       = '0;
      seq_position_next    = '0;
      seq_bad_next         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      bytes_remaining <= '0;
      lead_byte       <= '0;
      seq_position    <= '0;
      seq_bad         <= 1'b0;
      halted          <= 1'b0;
    end else if (fire) begin
      partial_value   <= partial_value_next;
      bytes_remaining <= bytes_remaining_next;
      lead_byte       <= lead_byte_next;
      seq_position    <= seq_position_next;
      seq_bad         <= seq_bad_next;
      halted          <= halted_next;
    end
  end

endmodule

### src/u8u16_out.sv
// Output register plus one holding slot for the low surrogate of a pair.
// Depends on u8u16_pkg.
module u8u16_out (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  u8u16_pkg::res_t      res,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [15:0]          code_unit,
  output logic [1:0]           status,
  output logic                 last_of_run,
  output u8u16_pkg::out_ctl_t  ctl
);
  import u8u16_pkg::*;

  logic        o_valid;
  logic        p_valid;
  logic [15:0] p_unit;
  logic        o_free;

  assign o_free    = !o_valid || !out_stall;
  assign ctl.free  = o_free;
  assign ctl.pend  = p_valid;
  assign out_valid = o_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      p_valid <= 1'b0;
    end else if (o_free) begin
      if (p_valid) begin
        o_valid <= 1'b1;
        p_valid <= 1'b0;
      end else if (fire && res.n != 2'd0) begin
        o_valid <= 1'b1;
        p_valid <= (res.n == 2'd2);
      end else begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_free) begin
      if (p_valid) begin
        code_unit   <= p_unit;
        status      <= ST_OK;
        last_of_run <= 1'b1;
      end else if (fire && res.n != 2'd0) begin
        code_unit   <= res.unit0;
        status      <= res.status0;
        last_of_run <= res.last0;
      end
    end
    if (fire) p_unit <= res.unit1;
  end

endmodule

### src/u8u16_checker.sv
// Port-level checks for the UTF-8 to UTF-16 decoder, bound to the top level.
// Depends on u8u16_pkg and the top level's ports.
module u8u16_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_byte,
  input logic        end_of_input,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] code_unit,
  input logic [1:0]  status,
  input logic        last_of_run
);
  import u8u16_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(code_unit) && $stable(status)
      && $stable(last_of_run))
    else $error("output word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_ILLEGAL || status == ST_CUTOFF))
    else $error("undefined status code");

  a_err_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last_of_run && code_unit == 16'h0000)
    else $error("error word not final or carries data");

  a_hi_surr: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> code_unit[15:10] == HI_SURR_BASE[15:10]
      && status == ST_OK)
    else $error("non-final word is not a high surrogate");

  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> out_valid && last_of_run
      && code_unit[15:10] == LO_SURR_PREFIX)
    else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_chk (.*);

### dv/tb_top.sv
// Self-checking testbench for utf8_to_utf16_decoder: a directed byte table, then
// random well-formed and broken UTF-8 streams, checked against a local decoder model.
// Depends on u8u16_pkg and the utf8_to_utf16_decoder RTL.
module tb_top;
  import u8u16_pkg::*;

  typedef struct packed {
    logic [15:0] cu;
    status_t     st;
    logic        lst;
  } word_t;

  typedef enum logic [1:0] {
    ROW_PRED,
    ROW_ONE,
    ROW_NONE
  } row_kind_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        e;
    row_kind_t   kind;
    logic [15:0] cu;
    status_t     st;
  } row_t;

  localparam int N_ROWS = 27;
  localparam int N_RANDOM = 1700;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] code_unit;
  logic [1:0]  status;
  logic        last_of_run;

  utf8_to_utf16_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .code_unit    (code_unit),
    .status       (status),
    .last_of_run  (last_of_run)
  );

  word_t pending_units [$];
  int    n_fail = 0;
  bit    in_calm = 1'b0;
  bit    out_calm = 1'b0;

  // decoder model state
  logic [20:0] acc;
  logic [2:0]  trail_left;
  logic [7:0]  seq_lead;
  logic [2:0]  seq_idx;
  logic        seq_err;
  logic        dropping;

  function automatic void clear_decoder();
    acc = '0;
    trail_left = '0;
    seq_lead = '0;
    seq_idx = '0;
    seq_err = 1'b0;
    dropping = 1'b0;
  endfunction

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    if (b[7:6] != 2'b11) return 3'd0;
    if (!b[5]) return 3'd1;
    if (!b[4]) return 3'd2;
    if (!b[3]) return 3'd3;
    if (!b[2]) return 3'd4;
    return 3'd5;
  endfunction

  // after ED and F4 only the upper bound applies
  function automatic logic second_fits(input logic [7:0] lead, input logic [7:0] b);
    if (b > CONT_MAX) return 1'b0;
    case (lead)
      LEAD_E0: return b >= E0_SECOND_MIN;
      LEAD_ED: return b <= ED_SECOND_MAX;
      LEAD_F0: return b >= F0_SECOND_MIN;
      LEAD_F4: return b <= F4_SECOND_MAX;
      default: return b >= CONT_MIN;
    endcase
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic e, output int cnt,
                                      output word_t w0, output word_t w1);
    logic [2:0]  t;
    logic [20:0] v;
    cnt = 0;
    w0 = '0;
    w1 = '0;
    if (dropping) begin
      if (e) clear_decoder();
      return;
    end
    if (trail_left == 3'd0) begin
      t = lead_len(b);
      if (t == 3'd0) begin
        cnt = 1;
        if (b[7]) begin
          w0 = '{16'h0000, ST_ILLEGAL, 1'b1};
          clear_decoder();
          dropping = !e;
        end else begin
          w0 = '{{8'h00, b}, ST_OK, 1'b1};
          if (e) clear_decoder();
        end
        return;
      end
      if (e) begin
        cnt = 1;
        w0 = '{16'h0000, ST_CUTOFF, 1'b1};
        clear_decoder();
        return;
      end
      seq_lead = b;
      trail_left = t;
      seq_idx = 3'd1;
      seq_err = (b < LEAD_MIN) || (b > LEAD_MAX) || (t > 3'd3);
      acc = (t == 3'd1) ? {16'h0, b[4:0]} : (t == 3'd2) ? {17'h0, b[3:0]} : {18'h0, b[2:0]};
      return;
    end
    if (seq_idx == 3'd1) begin
      if (!second_fits(seq_lead, b)) seq_err = 1'b1;
    end else if (b[7:6] != 2'b10) begin
      seq_err = 1'b1;
    end
    acc = {acc[14:0], b[5:0]};
    seq_idx = seq_idx + 3'd1;
    trail_left = trail_left - 3'd1;
    if (trail_left != 3'd0) begin
      if (e) begin
        cnt = 1;
        w0 = '{16'h0000, ST_CUTOFF, 1'b1};
        clear_decoder();
      end
      return;
    end
    cnt = 1;
    if (seq_err) begin
      w0 = '{16'h0000, ST_ILLEGAL, 1'b1};
      clear_decoder();
      dropping = !e;
      return;
    end
    if (acc <= BMP_MAX) begin
      w0 = '{acc[15:0], ST_OK, 1'b1};
    end else begin
      v = acc - SUPP_BASE;
      w0 = '{16'(v >> 10) + HI_SURR_BASE, ST_OK, 1'b0};
      w1 = '{{LO_SURR_PREFIX, v[9:0]}, ST_OK, 1'b1};
      cnt = 2;
    end
    clear_decoder();
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic drive_byte(input logic [7:0] b, input logic e);
    int g;
    if ($urandom_range(0, 99) == 0) in_calm = !in_calm;
    g = pick_gap(in_calm);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    end_of_input <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drive one byte, predict it, queue what it should produce
  task automatic feed_byte(input logic [7:0] b, input logic e, inout int n_taken);
    int    cnt;
    word_t w0;
    word_t w1;
    drive_byte(b, e);
    n_taken++;
    decode_byte(b, e, cnt, w0, w1);
    if (cnt > 0) pending_units.push_back(w0);
    if (cnt > 1) pending_units.push_back(w1);
  endtask

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    int g;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 99) == 0) out_calm = !out_calm;
      g = pick_gap(out_calm);
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    word_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_units.size() == 0) begin
        $display("%0t: unexpected word, expected none, got cu=%h st=%0d last=%b",
                 $time, code_unit, status, last_of_run);
        n_fail++;
      end else begin
        w = pending_units.pop_front();
        if (code_unit !== w.cu) begin
          $display("%0t: code_unit expected %h got %h", $time, w.cu, code_unit);
          n_fail++;
        end
        if (status !== w.st) begin
          $display("%0t: status expected %0d got %0d", $time, w.st, status);
          n_fail++;
        end
        if (last_of_run !== w.lst) begin
          $display("%0t: last_of_run expected %b got %b", $time, w.lst, last_of_run);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    row_t       plan [N_ROWS];
    int         cnt;
    int         n_taken;
    int         r;
    int         len;
    int         k;
    logic [7:0] sq [6];
    logic [7:0] ld;
    word_t      w0;
    word_t      w1;

    plan = '{
      '{8'h00, 1'b0, ROW_ONE,  16'h0000, ST_OK},
      '{8'h7F, 1'b1, ROW_ONE,  16'h007F, ST_OK},
      '{8'h80, 1'b1, ROW_ONE,  16'h0000, ST_ILLEGAL},
      '{8'hC2, 1'b0, ROW_NONE, 16'h0000, ST_OK},
      '{8'h80, 1'b0, ROW_PRED, 16'h0000, ST_OK},
      '{8'hDF, 1'b0, ROW_NONE, 16'h0000, ST_OK},
      '{8'hBF, 1'b0, ROW_PRED, 16'h0000, ST_OK},
      '{8'hE0, 1'b0, ROW_NONE, 16'h0000, ST_OK},
      '{8'hA0, 1'b0, ROW_NONE, 16'h0000, ST_OK},
      '{8'h80, 1'b0, ROW_PRED, 16'h0000, ST_OK},
      '{8'hED, 1'b0, ROW_NONE, 16'h0000, ST_OK},
      '{8'h9F, 1'b0, ROW_NONE, 16'h0000, ST_OK},
      '{8'hBF, 1'b1, ROW_PRED, 16'h0000, ST_OK},
      '{8'hF0, 1'b0, ROW_NONE, 16'h0000, ST_OK},
      '{8'h90, 1'b0, ROW_NONE, 16'h0000, ST_OK},
      '{8'h80, 1'b0, ROW_NONE, 16'h0000, ST_OK},
      '{8'h80, 1'b0, ROW_PRED, 16'h0000, ST_OK},
      '{8'hF4, 1'b0, ROW_NONE, 16'h0000, ST_OK},
      '{8'h8F, 1'b0, ROW_NONE, 16'h0000, ST_OK},
      '{8'hBF, 1'b0, ROW_NONE, 16'h0000, ST_OK},
      '{8'hBF, 1'b1, ROW_PRED, 16'h0000, ST_OK},
      '{8'hC0, 1'b0, ROW_NONE, 16'h0000, ST_OK},
      '{8'h80, 1'b0, ROW_ONE,  16'h0000, ST_ILLEGAL},
      '{8'hFF, 1'b1, ROW_NONE, 16'h0000, ST_OK},
      '{8'hE1, 1'b1, ROW_ONE,  16'h0000, ST_CUTOFF},
      '{8'hE0, 1'b0, ROW_NONE, 16'h0000, ST_OK},
      '{8'h80, 1'b1, ROW_ONE,  16'h0000, ST_CUTOFF}
    };

    clear_decoder();
    n_taken = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      drive_byte(plan[i].b, plan[i].e);
      decode_byte(plan[i].b, plan[i].e, cnt, w0, w1);
      case (plan[i].kind)
        ROW_ONE: pending_units.push_back('{plan[i].cu, plan[i].st, 1'b1});
        ROW_PRED: begin
          if (cnt > 0) pending_units.push_back(w0);
          if (cnt > 1) pending_units.push_back(w1);
        end
        default: ;
      endcase
    end

    n_taken = 0;
    while (n_taken < N_RANDOM) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        // well-formed sequence, sometimes corrupted or cut short
        len = $urandom_range(1, 4);
        case (len)
          1: sq[0] = 8'($urandom_range(0, 127));
          2: sq[0] = 8'($urandom_range(8'hC2, 8'hDF));
          3: sq[0] = 8'($urandom_range(8'hE0, 8'hEF));
          default: sq[0] = 8'($urandom_range(8'hF0, 8'hF4));
        endcase
        for (k = 1; k < len; k++) sq[k] = 8'($urandom_range(8'h80, 8'hBF));
        ld = sq[0];
        if (ld == LEAD_E0) sq[1] = 8'($urandom_range(8'hA0, 8'hBF));
        if (ld == LEAD_ED) sq[1] = 8'($urandom_range(8'h80, 8'h9F));
        if (ld == LEAD_F0) sq[1] = 8'($urandom_range(8'h90, 8'hBF));
        if (ld == LEAD_F4) sq[1] = 8'($urandom_range(8'h80, 8'h8F));
        if ($urandom_range(0, 9) == 0) sq[$urandom_range(0, len - 1)] = 8'($urandom);
      end else if (r < 86) begin
        // lead that is always rejected, followed by its full trail, sometimes cut short
        case ($urandom_range(0, 3))
          0: ld = 8'($urandom_range(8'hC0, 8'hC1));
          1: ld = 8'($urandom_range(8'hF5, 8'hF7));
          2: ld = 8'($urandom_range(8'hF8, 8'hFB));
          default: ld = 8'($urandom_range(8'hFC, 8'hFF));
        endcase
        len = int'(lead_len(ld)) + 1;
        sq[0] = ld;
        for (k = 1; k < len; k++) sq[k] = 8'($urandom_range(8'h80, 8'hBF));
      end else begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++) sq[k] = 8'($urandom);
      end
      if (r >= 86) begin
        for (k = 0; k < len; k++) feed_byte(sq[k], $urandom_range(0, 4) == 0, n_taken);
      end else if ($urandom_range(0, 19) == 0 && len > 1) begin
        k = $urandom_range(1, len - 1);
        for (int j = 0; j < k; j++) feed_byte(sq[j], j == k - 1, n_taken);
      end else begin
        for (k = 0; k < len; k++)
          feed_byte(sq[k], (k == len - 1) && ($urandom_range(0, 6) == 0), n_taken);
      end
    end
    in_valid <= 1'b0;

    while (pending_units.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
